// ----- rtl/skvt_pkg.sv -----
// shared types and constants for the sorted key/value table
package skvt_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_W            = 32;
    localparam int VALUE_W          = 32;
    localparam int CMD_W            = 3;
    localparam int STATUS_W         = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_FIRST  = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_STORE  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 3'd0,
        STATUS_ABSENT  = 3'd1,
        STATUS_PRESENT = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_BAD_KEY = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

// ----- rtl/skvt_ctrl.sv -----
// request sequencer: capture, commit and result handshake
module skvt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output skvt_pkg::dp_cmd_t dp_cmd
);

    skvt_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skvt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        case (state_reg)
            skvt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = skvt_pkg::ST_EXEC;
                end
            end
            skvt_pkg::ST_EXEC: begin
                // commit only once the result register is free
                if (!out_valid_reg || m_ready) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = skvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (dp_cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ----- rtl/skvt_cells.sv -----
// datapath: sorted cell chain with parallel compare, shift and result register
module skvt_cells #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  skvt_pkg::dp_cmd_t                   dp_cmd,
    input  logic [skvt_pkg::CMD_W-1:0]          s_cmd,
    input  logic signed [skvt_pkg::KEY_W-1:0]   s_key,
    input  logic signed [skvt_pkg::VALUE_W-1:0] s_entry_value,
    output logic                                m_ok,
    output logic [skvt_pkg::STATUS_W-1:0]       m_status,
    output logic signed [skvt_pkg::KEY_W-1:0]   m_out_key,
    output logic signed [skvt_pkg::VALUE_W-1:0] m_out_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [skvt_pkg::KEY_W-1:0]   key_reg   [CAPACITY];
    logic signed [skvt_pkg::VALUE_W-1:0] value_reg [CAPACITY];
    logic [CW-1:0]                       count_reg, count_next;

    logic [skvt_pkg::CMD_W-1:0]          req_cmd_reg;
    logic signed [skvt_pkg::KEY_W-1:0]   req_key_reg;
    logic signed [skvt_pkg::VALUE_W-1:0] req_value_reg;

    // per-cell compare flags against the request key, valid cells only
    logic [CAPACITY-1:0] lt_reg, eq_reg, gt_reg;
    logic [CAPACITY-1:0] lt_next, eq_next, gt_next;
    logic [CAPACITY-1:0] lt_prev, gt_prev, nx_sel;

    logic                                ok_reg;
    skvt_pkg::status_t                   status_reg, status_next;
    logic signed [skvt_pkg::KEY_W-1:0]   okey_reg, okey_next;
    logic signed [skvt_pkg::VALUE_W-1:0] oval_reg, oval_next;

    logic hit, full, next_found;
    logic do_insert, do_delete, do_write;
    logic signed [skvt_pkg::KEY_W-1:0]   next_key;
    logic signed [skvt_pkg::VALUE_W-1:0] find_value;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt_next[i] = (CW'(i) < count_reg) && (key_reg[i] <  s_key);
            eq_next[i] = (CW'(i) < count_reg) && (key_reg[i] == s_key);
            gt_next[i] = (CW'(i) < count_reg) && (key_reg[i] >  s_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            req_cmd_reg   <= s_cmd;
            req_key_reg   <= s_key;
            req_value_reg <= s_entry_value;
            lt_reg        <= lt_next;
            eq_reg        <= eq_next;
            gt_reg        <= gt_next;
        end
    end

    // keys are sorted, so lt and gt are runs; edges mark insert point and successor
    assign lt_prev = {lt_reg[CAPACITY-2:0], 1'b1};
    assign gt_prev = {gt_reg[CAPACITY-2:0], 1'b0};
    assign nx_sel  = gt_reg & ~gt_prev;

    assign hit        = |eq_reg;
    assign next_found = |gt_reg;
    assign full       = (count_reg == CW'(CAPACITY));

    always_comb begin
        find_value = '0;
        next_key   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            find_value = find_value | (eq_reg[i] ? value_reg[i] : '0);
            next_key   = next_key   | (nx_sel[i] ? key_reg[i]   : '0);
        end
    end

    always_comb begin
        status_next = skvt_pkg::STATUS_DONE;
        okey_next   = '0;
        oval_next   = '0;
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        do_write    = 1'b0;
        case (req_cmd_reg)
            skvt_pkg::CMD_ADD: begin
                if (hit) begin
                    status_next = skvt_pkg::STATUS_PRESENT;
                end else if (full) begin
                    status_next = skvt_pkg::STATUS_FULL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            skvt_pkg::CMD_DELETE: begin
                if (!hit) begin
                    status_next = skvt_pkg::STATUS_ABSENT;
                end else begin
                    do_delete = 1'b1;
                end
            end
            skvt_pkg::CMD_UPDATE: begin
                if (!hit) begin
                    status_next = skvt_pkg::STATUS_ABSENT;
                end else begin
                    do_write = 1'b1;
                end
            end
            skvt_pkg::CMD_FIND: begin
                if (!hit) begin
                    status_next = skvt_pkg::STATUS_ABSENT;
                end else begin
                    oval_next = find_value;
                end
            end
            skvt_pkg::CMD_FIRST: begin
                if (count_reg == '0) begin
                    status_next = skvt_pkg::STATUS_ABSENT;
                end else begin
                    okey_next = key_reg[0];
                end
            end
            skvt_pkg::CMD_NEXT: begin
                if (!next_found) begin
                    status_next = skvt_pkg::STATUS_ABSENT;
                end else begin
                    okey_next = next_key;
                end
            end
            skvt_pkg::CMD_STORE: begin
                if (req_key_reg <= 0) begin
                    status_next = skvt_pkg::STATUS_BAD_KEY;
                end else if (hit) begin
                    do_write = 1'b1;
                end else if (full) begin
                    status_next = skvt_pkg::STATUS_FULL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            default: begin
                status_next = skvt_pkg::STATUS_BAD_KEY;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (dp_cmd.commit) begin
                if (do_insert && !lt_reg[g]) begin
                    if (lt_prev[g]) begin
                        key_reg[g]   <= req_key_reg;
                        value_reg[g] <= req_value_reg;
                    end else begin
                        key_reg[g]   <= key_reg[(g > 0) ? g - 1 : 0];
                        value_reg[g] <= value_reg[(g > 0) ? g - 1 : 0];
                    end
                end else if (do_delete && !lt_reg[g] && (g < CAPACITY - 1)) begin
                    key_reg[g]   <= key_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    value_reg[g] <= value_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end else if (do_write && eq_reg[g]) begin
                    value_reg[g] <= req_value_reg;
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (dp_cmd.commit && do_insert) begin
            count_next = count_reg + CW'(1);
        end else if (dp_cmd.commit && do_delete) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            ok_reg     <= (status_next == skvt_pkg::STATUS_DONE);
            status_reg <= status_next;
            okey_reg   <= okey_next;
            oval_reg   <= oval_next;
        end
    end

    assign m_ok        = ok_reg;
    assign m_status    = status_reg;
    assign m_out_key   = okey_reg;
    assign m_out_value = oval_reg;

endmodule

// ----- rtl/sorted_key_value_table.sv -----
// Sorted key/value table: holds up to CAPACITY pairs in ascending signed Q16.16
// key order in a chain of cells and answers each request with one result beat.
// In the cycle a request is accepted every cell compares its key with the request
// key at once and the flags are registered; once the result register is free the
// chain shifts, updates and loads the result register. Another request is
// accepted in the cycle after that, so a new request is not taken before the
// last one is committed; a result that is not taken holds the commit of the
// following request. Stored entries are undefined until written and are never
// read beyond the fill count, so no clearing is needed after reset.
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [skvt_pkg::CMD_W-1:0]          s_cmd,
    input  logic signed [skvt_pkg::KEY_W-1:0]   s_key,
    input  logic signed [skvt_pkg::VALUE_W-1:0] s_entry_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok,
    output logic [skvt_pkg::STATUS_W-1:0]       m_status,
    output logic signed [skvt_pkg::KEY_W-1:0]   m_out_key,
    output logic signed [skvt_pkg::VALUE_W-1:0] m_out_value
);

    skvt_pkg::dp_cmd_t dp_cmd;

    skvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    skvt_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dp_cmd        (dp_cmd),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_entry_value (s_entry_value),
        .m_ok          (m_ok),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_value   (m_out_value)
    );

    // a committed request always presents a result beat
    a_commit_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.commit |=> m_valid)
        else $error("commit did not raise m_valid");

    a_capture_commit_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_cmd.capture && dp_cmd.commit))
        else $error("capture and commit in the same cycle");

    a_ok_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ok == (m_status == skvt_pkg::STATUS_DONE)))
        else $error("ok disagrees with status");

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request accepted before commit");

endmodule
